>>> hw/rtl/gahr_pkg.sv
// gahr_pkg: shared widths, types, register indexes and hat encoding
// for the gamepad axis and hat reporter
// no dependencies
package gahr_pkg;

    // field widths
    localparam int BUTTON_W    = 32;
    localparam int PAD_W       = 4;
    localparam int HAT_W       = 4;
    localparam int SAMPLE_W    = 12;
    localparam int SAMPLE_DROP = 4;
    localparam int AXIS_W      = 8;
    localparam int AXES        = 6;
    localparam int SEL_W       = 3;
    localparam int OFS_W       = 8;
    localparam int GAIN_W      = 8;
    localparam int DB_W        = 16;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_CH      = 4;

    // output item packing
    localparam int OUT_W       = BUTTON_W + HAT_W + AXES * AXIS_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // saturation limits of an axis value
    localparam int AXIS_MIN = -128;
    localparam int AXIS_MAX = 127;

    // register reset values
    localparam logic [MAX_CH*SEL_W-1:0] AXIS_SELECT_RST = 12'hFFF;
    localparam logic [MAX_CH*OFS_W-1:0] OFFSETS_RST     = 32'h0000_0000;
    localparam logic [MAX_CH*GAIN_W-1:0] GAINS_RST      = 32'h0101_0101;

    typedef logic signed [AXIS_W-1:0] axis_val_t;

    // per-channel result handed to the axis merge
    typedef struct packed {
        logic                 drive;
        logic [SEL_W-1:0]     sel;
        axis_val_t            value;
    } chan_res_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_SELECT   = 3'd0,
        REG_OFFSETS       = 3'd1,
        REG_GAINS         = 3'd2,
        REG_DEADBAND_LOW  = 3'd3,
        REG_DEADBAND_HIGH = 3'd4
    } cfg_reg_t;

    // direction pad words that map to a hat position
    localparam logic [PAD_W-1:0] PAD_RIGHT      = 4'b0001;
    localparam logic [PAD_W-1:0] PAD_UP         = 4'b0010;
    localparam logic [PAD_W-1:0] PAD_UP_RIGHT   = 4'b0011;
    localparam logic [PAD_W-1:0] PAD_DOWN       = 4'b0100;
    localparam logic [PAD_W-1:0] PAD_DOWN_RIGHT = 4'b0101;
    localparam logic [PAD_W-1:0] PAD_LEFT       = 4'b1000;
    localparam logic [PAD_W-1:0] PAD_UP_LEFT    = 4'b1010;
    localparam logic [PAD_W-1:0] PAD_DOWN_LEFT  = 4'b1100;

    // hat codes
    localparam logic [HAT_W-1:0] HAT_CENTER     = 4'd0;
    localparam logic [HAT_W-1:0] HAT_UP         = 4'd1;
    localparam logic [HAT_W-1:0] HAT_UP_RIGHT   = 4'd2;
    localparam logic [HAT_W-1:0] HAT_RIGHT      = 4'd3;
    localparam logic [HAT_W-1:0] HAT_DOWN_RIGHT = 4'd4;
    localparam logic [HAT_W-1:0] HAT_DOWN       = 4'd5;
    localparam logic [HAT_W-1:0] HAT_DOWN_LEFT  = 4'd6;
    localparam logic [HAT_W-1:0] HAT_LEFT       = 4'd7;
    localparam logic [HAT_W-1:0] HAT_UP_LEFT    = 4'd8;

    // pad word to hat code, conflicting directions read as centered
    function automatic logic [HAT_W-1:0] encode_hat(input logic [PAD_W-1:0] pad);
        logic [HAT_W-1:0] hat;
        unique case (pad)
            PAD_RIGHT:      hat = HAT_RIGHT;
            PAD_UP:         hat = HAT_UP;
            PAD_UP_RIGHT:   hat = HAT_UP_RIGHT;
            PAD_DOWN:       hat = HAT_DOWN;
            PAD_DOWN_RIGHT: hat = HAT_DOWN_RIGHT;
            PAD_LEFT:       hat = HAT_LEFT;
            PAD_UP_LEFT:    hat = HAT_UP_LEFT;
            PAD_DOWN_LEFT:  hat = HAT_DOWN_LEFT;
            default:        hat = HAT_CENTER;
        endcase
        return hat;
    endfunction

endpackage

>>> hw/rtl/gahr_chan.sv
// gahr_chan: one converter channel, offset, signed gain, dead band and saturation
// depends on gahr_pkg
module gahr_chan
(
    input  logic [gahr_pkg::SAMPLE_W-1:0]      sample,
    input  logic [gahr_pkg::SEL_W-1:0]         sel,
    input  logic [gahr_pkg::OFS_W-1:0]         offset,
    input  logic signed [gahr_pkg::GAIN_W-1:0] gain,
    input  logic signed [gahr_pkg::DB_W-1:0]   db_low,
    input  logic signed [gahr_pkg::DB_W-1:0]   db_high,
    output gahr_pkg::chan_res_t                res
);

    localparam int RED_W  = gahr_pkg::SAMPLE_W - gahr_pkg::SAMPLE_DROP;
    localparam int DIFF_W = RED_W + 1;
    localparam int PROD_W = DIFF_W + gahr_pkg::GAIN_W;

    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(gahr_pkg::AXIS_MIN);
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(gahr_pkg::AXIS_MAX);

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] lo_ext;
    logic signed [PROD_W-1:0] hi_ext;
    logic                     in_band;
    logic                     sel_ok;
    gahr_pkg::axis_val_t      sat_val;

    // reduce the sample to eight bits and remove the offset
    assign diff = $signed({1'b0, sample[gahr_pkg::SAMPLE_W-1:gahr_pkg::SAMPLE_DROP]})
                - $signed({1'b0, offset});

    // signed scale, exact at this width
    assign prod = diff * gain;

    // dead band test
    assign lo_ext  = PROD_W'(db_low);
    assign hi_ext  = PROD_W'(db_high);
    assign in_band = (prod >= lo_ext) && (prod <= hi_ext);

    // clamp to the axis range
    always_comb
    begin
        if (prod < SAT_LO)
        begin
            sat_val = gahr_pkg::axis_val_t'(SAT_LO);
        end
        else if (prod > SAT_HI)
        begin
            sat_val = gahr_pkg::axis_val_t'(SAT_HI);
        end
        else
        begin
            sat_val = prod[gahr_pkg::AXIS_W-1:0];
        end
    end

    // channels with a select above the last axis stay off
    assign sel_ok = (sel < gahr_pkg::SEL_W'(gahr_pkg::AXES));

    assign res.drive = sel_ok && !in_band;
    assign res.sel   = sel;
    assign res.value = sat_val;

endmodule

>>> hw/rtl/gamepad_axis_and_hat_reporter_core.sv
// gamepad_axis_and_hat_reporter_core: input item register, channel scaling,
// axis merge, hat encode and report register; uses gahr_pkg and gahr_chan
// an item passes the input register, then the report register, to the master side
// throughput: one item per cycle; a held report stalls the input only when the
// input register also holds an item that must emit
// reset: handshake state and the idle-report flag clear, configuration registers take defaults
module gamepad_axis_and_hat_reporter_core
#(
    parameter int CHANNELS = 4
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration write port
    input  logic                                  cfg_we,
    input  logic [gahr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gahr_pkg::CFG_W-1:0]            cfg_wdata,

    // input items
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // button_bits[31:0], pad_bits[35:32], sample_ch0 .. sample_ch(CHANNELS-1)
    // 12 bits each from bit 36 up, zero fill to whole bytes
    input  logic [((gahr_pkg::BUTTON_W + gahr_pkg::PAD_W
                    + gahr_pkg::SAMPLE_W * CHANNELS + 7) / 8) * 8 - 1:0] s_axis_tdata,

    // result items
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // report_buttons[31:0], hat_code[35:32], axis_x[43:36], axis_y[51:44],
    // axis_z[59:52], axis_rz[67:60], axis_rx[75:68], axis_ry[83:76], zero fill
    output logic [gahr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int SW = gahr_pkg::SAMPLE_W;
    localparam int S0 = gahr_pkg::BUTTON_W + gahr_pkg::PAD_W;

    // configuration registers
    logic [gahr_pkg::MAX_CH*gahr_pkg::SEL_W-1:0]  axis_select_reg;
    logic [gahr_pkg::MAX_CH*gahr_pkg::OFS_W-1:0]  offsets_reg;
    logic [gahr_pkg::MAX_CH*gahr_pkg::GAIN_W-1:0] gains_reg;
    logic signed [gahr_pkg::DB_W-1:0]             db_low_reg;
    logic signed [gahr_pkg::DB_W-1:0]             db_high_reg;

    // input item register
    logic                                         s1_valid_reg;
    logic                                         s1_valid_next;
    logic [gahr_pkg::BUTTON_W-1:0]                s1_buttons_reg;
    logic [gahr_pkg::PAD_W-1:0]                   s1_pad_reg;
    logic [SW-1:0]                                s1_samples_reg [CHANNELS];

    // report register
    logic                                         s2_valid_reg;
    logic                                         s2_valid_next;
    logic [gahr_pkg::BUTTON_W-1:0]                s2_buttons_reg;
    logic [gahr_pkg::HAT_W-1:0]                   s2_hat_reg;
    gahr_pkg::axis_val_t                          s2_axes_reg [gahr_pkg::AXES];

    logic                                         idle_sent_reg;
    logic                                         idle_sent_next;

    // combinational work on the held item
    gahr_pkg::chan_res_t                          chan_res [CHANNELS];
    gahr_pkg::axis_val_t                          axes [gahr_pkg::AXES];
    logic [gahr_pkg::HAT_W-1:0]                   hat;
    logic                                         nonzero;
    logic                                         emit;
    logic                                         s2_free;
    logic                                         s1_go;
    logic                                         s1_take;
    logic                                         s2_load;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_select_reg <= gahr_pkg::AXIS_SELECT_RST;
            offsets_reg     <= gahr_pkg::OFFSETS_RST;
            gains_reg       <= gahr_pkg::GAINS_RST;
            db_low_reg      <= '0;
            db_high_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gahr_pkg::REG_AXIS_SELECT:
                    axis_select_reg <= cfg_wdata[gahr_pkg::MAX_CH*gahr_pkg::SEL_W-1:0];
                gahr_pkg::REG_OFFSETS:
                    offsets_reg <= cfg_wdata[gahr_pkg::MAX_CH*gahr_pkg::OFS_W-1:0];
                gahr_pkg::REG_GAINS:
                    gains_reg <= cfg_wdata[gahr_pkg::MAX_CH*gahr_pkg::GAIN_W-1:0];
                gahr_pkg::REG_DEADBAND_LOW:
                    db_low_reg <= cfg_wdata[gahr_pkg::DB_W-1:0];
                gahr_pkg::REG_DEADBAND_HIGH:
                    db_high_reg <= cfg_wdata[gahr_pkg::DB_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // per-channel scaling
    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_chan
        gahr_chan u_chan
        (
            .sample  (s1_samples_reg[ch]),
            .sel     (axis_select_reg[gahr_pkg::SEL_W*ch +: gahr_pkg::SEL_W]),
            .offset  (offsets_reg[gahr_pkg::OFS_W*ch +: gahr_pkg::OFS_W]),
            .gain    (gains_reg[gahr_pkg::GAIN_W*ch +: gahr_pkg::GAIN_W]),
            .db_low  (db_low_reg),
            .db_high (db_high_reg),
            .res     (chan_res[ch])
        );
    end

    // axis merge, later channels override earlier ones
    always_comb
    begin
        for (int a = 0; a < gahr_pkg::AXES; a++)
        begin
            axes[a] = '0;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                if (chan_res[ch].drive && (chan_res[ch].sel == gahr_pkg::SEL_W'(a)))
                begin
                    axes[a] = chan_res[ch].value;
                end
            end
        end
    end

    assign hat = gahr_pkg::encode_hat(s1_pad_reg);

    // report content test
    always_comb
    begin
        nonzero = (s1_buttons_reg != '0) || (hat != gahr_pkg::HAT_CENTER);
        for (int a = 0; a < gahr_pkg::AXES; a++)
        begin
            if (axes[a] != '0)
            begin
                nonzero = 1'b1;
            end
        end
    end

    // handshake and flow control
    assign emit          = nonzero || !idle_sent_reg;
    assign s2_free       = !s2_valid_reg || m_axis_tready;
    assign s1_go         = s1_valid_reg && (!emit || s2_free);
    assign s2_load       = s1_go && emit;
    assign s_axis_tready = !s1_valid_reg || s1_go;
    assign s1_take       = s_axis_tvalid && s_axis_tready;

    assign s1_valid_next = s1_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s2_load ? 1'b1 : (m_axis_tready ? 1'b0 : s2_valid_reg);
    assign idle_sent_next = s1_go ? !nonzero : idle_sent_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            idle_sent_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            idle_sent_reg <= idle_sent_next;
        end
    end

    // input item payload
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_buttons_reg <= s_axis_tdata[gahr_pkg::BUTTON_W-1:0];
            s1_pad_reg     <= s_axis_tdata[gahr_pkg::BUTTON_W +: gahr_pkg::PAD_W];
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                s1_samples_reg[ch] <= s_axis_tdata[S0 + SW*ch +: SW];
            end
        end
    end

    // report payload
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_buttons_reg <= s1_buttons_reg;
            s2_hat_reg     <= hat;
            for (int a = 0; a < gahr_pkg::AXES; a++)
            begin
                s2_axes_reg[a] <= axes[a];
            end
        end
    end

    // output packing
    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[gahr_pkg::BUTTON_W-1:0] = s2_buttons_reg;
        m_axis_tdata[gahr_pkg::BUTTON_W +: gahr_pkg::HAT_W] = s2_hat_reg;
        for (int a = 0; a < gahr_pkg::AXES; a++)
        begin
            m_axis_tdata[gahr_pkg::BUTTON_W + gahr_pkg::HAT_W + gahr_pkg::AXIS_W*a
                         +: gahr_pkg::AXIS_W] = s2_axes_reg[a];
        end
    end

    assign m_axis_tvalid = s2_valid_reg;

`ifndef ASSERT_OFF
    // a held all-zero report implies the idle flag is set
    a_zero_report_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (m_axis_tdata == '0)) |-> idle_sent_reg)
        else $error("zero report held without idle flag");

    // a report is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |-> (!s2_valid_reg || m_axis_tready))
        else $error("report register overwritten");

    // a second zero report in a row is dropped
    a_single_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && !nonzero && idle_sent_reg) |-> !s2_load)
        else $error("repeated zero report");

    // an empty input register always takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_axis_tready)
        else $error("input stalled while empty");
`endif

endmodule
